// ===== hdl/rc_link_frame_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// RC link frame parser - assertion macros
// Concurrent assertion wrappers on clk; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef RC_LINK_FRAME_PARSER_UNIT_DEFINES_SVH
`define RC_LINK_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define RLFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define RLFP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLFP_ASSERT(lbl, prop, msg)
`define RLFP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hdl/rlfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfp_pkg
// Shared constants, codes and types of the RC link frame parser.
// ----------------------------------------------------------------------------
package rlfp_pkg;

  localparam int PAYLOAD_MAX  = 60;
  localparam int FRAME_BYTES  = 64;
  localparam int LEN_MIN      = 2;
  localparam int LEN_MAX      = PAYLOAD_MAX + 2;
  localparam int HDR_BYTES    = 2;               // sync and length bytes

  localparam int TYPE_POS       = 2;             // store place of the type byte
  localparam int PAYLOAD_FIRST  = 3;             // store place of payload byte 0
  localparam int RC_PAYLOAD     = 22;            // packed channel bytes
  localparam int STORE_LAST     = PAYLOAD_FIRST + RC_PAYLOAD - 1;
  localparam int PAYLOAD_W      = RC_PAYLOAD * 8;

  localparam int CHAN_COUNT = 16;
  localparam int CHAN_W     = 11;
  localparam int LINK_COUNT = 10;
  localparam int STAT_W     = 8;
  localparam int IDX_W      = 4;
  localparam int VALUE_W    = 11;

  localparam int POS_W = 7;
  localparam int GAP_W = 9;
  localparam int AGE_W = 17;
  localparam int CNT_W = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  CRC_POLY        = 8'hD5;
  localparam logic [7:0]  SYNC_RST        = 8'd200;
  localparam logic [7:0]  RC_TYPE_RST     = 8'd22;
  localparam logic [7:0]  LINK_TYPE_RST   = 8'd20;
  localparam logic [7:0]  GAP_LIMIT_RST   = 8'd5;
  localparam logic [15:0] FS_LIMIT_RST    = 16'd500;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_CHAN     = 3'd0,
    KIND_LINK     = 3'd1,
    KIND_OTHER    = 3'd2,
    KIND_CRC_ERR  = 3'd3,
    KIND_FAILSAFE = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC      = 3'd0,
    CFG_RC_TYPE   = 3'd1,
    CFG_LINK_TYPE = 3'd2,
    CFG_GAP_LIMIT = 3'd3,
    CFG_FS_LIMIT  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             failsafe;
    logic             connected;
    logic [CNT_W-1:0] good;
    logic [CNT_W-1:0] bad;
  } status_t;

  // one request from the front end to the result sequencer
  typedef struct packed {
    kind_t                kind;
    logic [PAYLOAD_W-1:0] payload;
    status_t              status;
  } job_t;

  // CRC-8, MSB first
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/rc_link_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_parser_unit
// Path: an accepted input item's request is written into the queue, then
//   loaded into the sequencer, whose registers drive the outputs; the load
//   waits while the sequencer is still busy.
// Throughput: one input item per cycle while the 2-deep queue has room; the
//   sequencer emits one result per unstalled cycle: 16 for RC, 10 for link stats.
// Reset: sync active-low rst_n restores control state, frame store and config
//   in the reset cycle itself, no clearing pass; queue/sequencer data not reset.
// ----------------------------------------------------------------------------
//
// Structure
//   rlfp_front : takes bytes and millisecond ticks. Runs the sync / length /
//                body parser, the CRC-8 (0xD5), the byte-gap and failsafe
//                timeouts, the good/bad counters and the config registers.
//                Whenever an input causes results it classifies them and
//                pushes one request: the kind, a snapshot of the 22 payload
//                bytes and the status after that input.
//   rlfp_queue : 2-entry FIFO of requests. Input is stalled only while full.
//   rlfp_back  : expands a request into result items. Channels come out of a
//                shift register 11 bits at a time, link stat bytes 8 at a
//                time; status kinds give a single item.
//
// Only store places 2..24 (type and first 22 payload bytes) are ever read,
// so only those are kept; the other positions still go through the CRC.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_unit import rlfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [7:0]            in_rx_byte,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_result_kind,
  output logic [IDX_W-1:0]      out_item_index,
  output logic [VALUE_W-1:0]    out_item_value,
  output logic                  out_last_of_run,
  output logic                  out_failsafe_flag,
  output logic                  out_connected,
  output logic [CNT_W-1:0]      out_good_frames,
  output logic [CNT_W-1:0]      out_bad_frames
);

  // front -> queue
  logic q_push;
  job_t q_push_job;
  logic q_full;

  // queue -> back
  logic q_pop;
  logic q_valid;
  job_t q_pop_job;

  rlfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_rx_byte  (in_rx_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (q_push),
    .job         (q_push_job)
  );

  rlfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_pop_job)
  );

  // request expansion; results of one input stay together and in order
  rlfp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_job             (q_pop_job),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_item_index    (out_item_index),
    .out_item_value    (out_item_value),
    .out_last_of_run   (out_last_of_run),
    .out_failsafe_flag (out_failsafe_flag),
    .out_connected     (out_connected),
    .out_good_frames   (out_good_frames),
    .out_bad_frames    (out_bad_frames)
  );

endmodule

// ===== hdl/rlfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfp_front
// Byte and tick intake: frame parser, CRC, timeouts, counters, config.
// ----------------------------------------------------------------------------
module rlfp_front import rlfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [7:0]            in_rx_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  push,
  output job_t                  job
);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_SYNC = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] total_len_r, total_len_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [GAP_W-1:0] gap_r, gap_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             fs_r, fs_nxt;
  logic [CNT_W-1:0] good_r, good_nxt;
  logic [CNT_W-1:0] bad_r, bad_nxt;
  logic [7:0]       store_r   [TYPE_POS:STORE_LAST];
  logic [7:0]       store_nxt [TYPE_POS:STORE_LAST];

  logic [7:0]       sync_r, rc_type_r, link_type_r, gap_lim_r;
  logic [15:0]      fs_lim_r;

  logic             accept;
  logic [POS_W-1:0] pos_inc;
  kind_t            kind_sel;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pos_inc  = pos_r + 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    total_len_nxt = total_len_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    gap_nxt       = gap_r;
    age_nxt       = age_r;
    fs_nxt        = fs_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    for (int i = TYPE_POS; i <= STORE_LAST; i++) begin
      store_nxt[i] = store_r[i];
    end
    push     = 1'b0;
    kind_sel = KIND_OTHER;

    if (accept) begin
      if (in_req_type) begin
        gap_nxt = (gap_r == '1) ? gap_r : gap_r + 1'b1;
        age_nxt = (age_r == '1) ? age_r : age_r + 1'b1;
        if (phase_r != PH_WAIT && gap_nxt > {1'b0, gap_lim_r}) begin
          phase_nxt = PH_WAIT;
          pos_nxt   = '0;
        end
        if (!fs_r && age_nxt > {1'b0, fs_lim_r}) begin
          fs_nxt   = 1'b1;
          push     = 1'b1;
          kind_sel = KIND_FAILSAFE;
        end
      end else begin
        gap_nxt = '0;
        unique case (phase_r)
          PH_SYNC: begin
            if (in_rx_byte >= 8'(LEN_MIN) && in_rx_byte <= 8'(LEN_MAX)) begin
              total_len_nxt = in_rx_byte[POS_W-1:0] + POS_W'(HDR_BYTES);
              pos_nxt       = POS_W'(HDR_BYTES);
              crc_nxt       = '0;
              phase_nxt     = PH_BODY;
            end else begin
              phase_nxt = PH_WAIT;
              pos_nxt   = '0;
            end
          end
          PH_BODY: begin
            for (int i = TYPE_POS; i <= STORE_LAST; i++) begin
              if (pos_r == POS_W'(i)) store_nxt[i] = in_rx_byte;
            end
            if (pos_inc >= total_len_r) begin
              push      = 1'b1;
              phase_nxt = PH_WAIT;
              pos_nxt   = '0;
              if (crc_r != in_rx_byte) begin
                bad_nxt  = bad_r + 1'b1;
                kind_sel = KIND_CRC_ERR;
              end else begin
                good_nxt = good_r + 1'b1;
                if (store_nxt[TYPE_POS] == rc_type_r) begin
                  kind_sel = KIND_CHAN;
                  age_nxt  = '0;
                  fs_nxt   = 1'b0;
                end else if (store_nxt[TYPE_POS] == link_type_r) begin
                  kind_sel = KIND_LINK;
                end else begin
                  kind_sel = KIND_OTHER;
                end
              end
            end else begin
              pos_nxt = pos_inc;
              crc_nxt = crc8_update(crc_r, in_rx_byte);
            end
          end
          default: begin
            // waiting for sync; the unused code behaves the same
            phase_nxt = PH_WAIT;
            pos_nxt   = '0;
            if (in_rx_byte == sync_r) begin
              phase_nxt = PH_SYNC;
              pos_nxt   = POS_W'(1);
            end
          end
        endcase
      end
    end

    job.kind = kind_sel;
    for (int j = 0; j < RC_PAYLOAD; j++) begin
      job.payload[8*j +: 8] = store_nxt[PAYLOAD_FIRST + j];
    end
    job.status.failsafe  = fs_nxt;
    job.status.connected = !fs_nxt && (good_nxt != '0);
    job.status.good      = good_nxt;
    job.status.bad       = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      total_len_r <= '0;
      pos_r       <= '0;
      crc_r       <= '0;
      gap_r       <= '0;
      age_r       <= '0;
      fs_r        <= 1'b1;
      good_r      <= '0;
      bad_r       <= '0;
      for (int i = TYPE_POS; i <= STORE_LAST; i++) begin
        store_r[i] <= '0;
      end
      sync_r      <= SYNC_RST;
      rc_type_r   <= RC_TYPE_RST;
      link_type_r <= LINK_TYPE_RST;
      gap_lim_r   <= GAP_LIMIT_RST;
      fs_lim_r    <= FS_LIMIT_RST;
    end else begin
      phase_r     <= phase_nxt;
      total_len_r <= total_len_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      gap_r       <= gap_nxt;
      age_r       <= age_nxt;
      fs_r        <= fs_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      for (int i = TYPE_POS; i <= STORE_LAST; i++) begin
        store_r[i] <= store_nxt[i];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SYNC:      sync_r      <= cfg_data[7:0];
          CFG_RC_TYPE:   rc_type_r   <= cfg_data[7:0];
          CFG_LINK_TYPE: link_type_r <= cfg_data[7:0];
          CFG_GAP_LIMIT: gap_lim_r   <= cfg_data[7:0];
          CFG_FS_LIMIT:  fs_lim_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/rlfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfp_queue
// Short request FIFO between the front end and the result sequencer.
// ----------------------------------------------------------------------------
`include "rc_link_frame_parser_unit_defines.svh"

module rlfp_queue import rlfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]  cnt_r;

  assign full      = (cnt_r == QC_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `RLFP_ASSERT(a_q_no_overflow, push |-> !full, "request queue written while full")
  `RLFP_ASSERT(a_q_no_underflow, pop |-> cnt_r != '0, "request queue read while empty")
  `RLFP_ASSERT(a_q_count, push && !pop |=> cnt_r == $past(cnt_r) + 1'b1, "queue count lost a push")

endmodule

// ===== hdl/rlfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfp_back
// Result sequencer: expands one request into 1, 10 or 16 result items.
// ----------------------------------------------------------------------------
`include "rc_link_frame_parser_unit_defines.svh"

module rlfp_back import rlfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  job_t               q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_result_kind,
  output logic [IDX_W-1:0]   out_item_index,
  output logic [VALUE_W-1:0] out_item_value,
  output logic               out_last_of_run,
  output logic               out_failsafe_flag,
  output logic               out_connected,
  output logic [CNT_W-1:0]   out_good_frames,
  output logic [CNT_W-1:0]   out_bad_frames
);

  logic                 busy_r;
  kind_t                kind_r;
  logic [IDX_W-1:0]     idx_r;
  logic [PAYLOAD_W-1:0] sh_r;
  status_t              status_r;

  logic out_acc;
  logic last;

  always_comb begin
    unique case (kind_r)
      KIND_CHAN: begin
        last           = (idx_r == IDX_W'(CHAN_COUNT - 1));
        out_item_value = sh_r[CHAN_W-1:0];
      end
      KIND_LINK: begin
        last           = (idx_r == IDX_W'(LINK_COUNT - 1));
        out_item_value = VALUE_W'(sh_r[STAT_W-1:0]);
      end
      default: begin
        last           = 1'b1;
        out_item_value = '0;
      end
    endcase
  end

  assign out_acc = busy_r && !out_stall;
  assign q_pop   = q_valid && (!busy_r || (out_acc && last));

  assign out_valid         = busy_r;
  assign out_result_kind   = kind_r;
  assign out_item_index    = idx_r;
  assign out_last_of_run   = last;
  assign out_failsafe_flag = status_r.failsafe;
  assign out_connected     = status_r.connected;
  assign out_good_frames   = status_r.good;
  assign out_bad_frames    = status_r.bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
    end else if (out_acc && last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= q_job.kind;
      idx_r    <= '0;
      sh_r     <= q_job.payload;
      status_r <= q_job.status;
    end else if (out_acc && !last) begin
      idx_r <= idx_r + 1'b1;
      sh_r  <= (kind_r == KIND_CHAN) ? (sh_r >> CHAN_W) : (sh_r >> STAT_W);
    end
  end

  `RLFP_ASSERT_RST(a_b_reset_idle, !rst_n |=> !out_valid, "result valid right after reset")
  `RLFP_ASSERT(a_b_idx_step, out_acc && !last |=> busy_r && idx_r == $past(idx_r) + 1'b1, "result index skipped")
  `RLFP_ASSERT(a_b_status_single, busy_r && kind_r != KIND_CHAN && kind_r != KIND_LINK |-> idx_r == '0 && last, "status result not single")

endmodule
